// File: rtl/sobol_sequence_generator_unit_macros.svh
// Assertion macros shared by the Sobol generator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef SOBOL_SEQUENCE_GENERATOR_UNIT_MACROS_SVH
`define SOBOL_SEQUENCE_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SOBOL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobol check failed");

// Next-cycle implication, checked outside reset.
`define SOBOL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobol check failed");

`endif

// File: rtl/sobol_pkg.sv
// Types and constants of the Sobol sequence generator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package sobol_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int WIN_DEPTH = 31;

  localparam logic [1:0] OP_LOAD_DIR  = 2'd0;
  localparam logic [1:0] OP_LOAD_POLY = 2'd1;
  localparam logic [1:0] OP_NEXT      = 2'd2;
  localparam logic [1:0] OP_RSVD      = 2'd3;

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_DIMS  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  dim_select;
    logic [5:0]  bit_position;
    logic [31:0] direction_value;
    logic [4:0]  poly_degree;
    logic [29:0] poly_coeffs;
  } sobol_in_t;

  typedef struct packed {
    logic [31:0] coordinate;
    logic [3:0]  coord_dim;
    logic        last_of_point;
    logic        exhausted;
  } sobol_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIM, ST_RD, ST_EX, ST_EMIT, ST_EXH, ST_CARRY
  } sobol_state_t;

  typedef struct packed {
    logic accept;
    logic point_start;
    logic dim_init;
    logic step;
    logic emit;
    logic exh;
    logic carry_init;
    logic carry_shift;
    logic point_done;
  } sobol_cmd_t;

  typedef struct packed {
    logic exhausted;
    logic direct;
    logic step_last;
    logic dim_last;
    logic points_zero;
    logic scan_lsb;
    logic out_free;
  } sobol_stat_t;

endpackage
`default_nettype wire

// File: rtl/sobol_ctrl.sv
// Controller state machine of the Sobol generator.
// Depends on sobol_pkg; drives the datapath through command and status structs.
`default_nettype none
module sobol_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_op,
  output logic                    in_ready,
  input  wire sobol_pkg::sobol_stat_t stat,
  output sobol_pkg::sobol_cmd_t   cmd
);
  import sobol_pkg::*;

  sobol_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_NEXT) begin
            if (stat.exhausted) begin
              state_nxt = ST_EXH;
            end else begin
              cmd.point_start = 1'b1;
              state_nxt       = ST_DIM;
            end
          end
        end
      end
      ST_DIM: begin
        if (stat.direct) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.dim_init = 1'b1;
          state_nxt    = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EX;
      end
      ST_EX: begin
        cmd.step  = 1'b1;
        state_nxt = stat.step_last ? ST_EMIT : ST_RD;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.dim_last) begin
            state_nxt = ST_DIM;
          end else if (stat.points_zero) begin
            cmd.point_done = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.carry_init = 1'b1;
            state_nxt      = ST_CARRY;
          end
        end
      end
      ST_CARRY: begin
        if (stat.scan_lsb) begin
          cmd.carry_shift = 1'b1;
        end else begin
          cmd.point_done = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_EXH: begin
        if (stat.out_free) begin
          cmd.exh   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/sobol_dp.sv
// Datapath of the Sobol generator: tables, direction recurrence, coordinates, output word.
// Depends on sobol_pkg and the assertion macros header.
`default_nettype none
`include "sobol_sequence_generator_unit_macros.svh"
module sobol_dp #(
  parameter int MAX_DIMS = 16,
  parameter int MAX_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sobol_pkg::sobol_in_t   in_data,
  input  wire sobol_pkg::sobol_cmd_t  cmd,
  output sobol_pkg::sobol_stat_t      stat,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [31:0]            cfg_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output sobol_pkg::sobol_out_t       out_data
);
  import sobol_pkg::*;

  localparam int DLIM  = (MAX_DIMS < NUM_SLOTS) ? MAX_DIMS : NUM_SLOTS;
  localparam int DEPTH = DLIM * MAX_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] dir_mem [DEPTH];
  logic [31:0] rdata_r;
  logic [4:0]  deg_r   [NUM_SLOTS];
  logic [29:0] coeff_r [NUM_SLOTS];
  logic [31:0] prev_r  [NUM_SLOTS];
  logic [31:0] win_r   [WIN_DEPTH];

  logic [32:0] points_r;
  logic [5:0]  carry_r;
  logic [31:0] limit_r;
  logic [4:0]  dims_r;
  logic [3:0]  d_r;
  logic [5:0]  i_r;
  logic [32:0] scan_r;
  logic [5:0]  t_r;
  logic        out_valid_r;
  sobol_out_t  out_r;

  logic [4:0]  s;
  logic [29:0] a;
  logic        c_ok, ld_dim_ok, ld_pos_ok, out_free;
  logic [4:0]  dims_eff;
  logic [31:0] shifted_m, rec, v_new, dv, v_final, x;
  logic [AW-1:0] wr_addr, rd_addr;
  int          wr_idx, rd_idx;

  assign s         = deg_r[d_r];
  assign a         = coeff_r[d_r];
  assign c_ok      = (carry_r != 6'd0) && (32'(carry_r) <= 32'(MAX_BITS));
  assign ld_dim_ok = (in_data.dim_select != 4'd0) && (32'(in_data.dim_select) < 32'(DLIM));
  assign ld_pos_ok = (in_data.bit_position != 6'd0)
                     && (32'(in_data.bit_position) <= 32'(MAX_BITS));
  assign out_free  = !out_valid_r || out_ready;

  assign wr_idx  = int'(in_data.dim_select) * MAX_BITS + int'(in_data.bit_position) - 1;
  assign rd_idx  = int'(d_r) * MAX_BITS + int'(i_r) - 1;
  assign wr_addr = wr_idx[AW-1:0];
  assign rd_addr = rd_idx[AW-1:0];

  always_comb begin
    if (dims_r == 5'd0) begin
      dims_eff = 5'd1;
    end else if (32'(dims_r) > 32'(DLIM)) begin
      dims_eff = 5'(DLIM);
    end else begin
      dims_eff = dims_r;
    end
  end

  // Direction step: table value up to bit position s, else window taps of recent values.
  always_comb begin
    logic [31:0] vb;
    int j;
    vb        = win_r[5'(s - 5'd1)];
    rec       = vb ^ (vb >> s);
    shifted_m = rdata_r << 5'(6'd32 - i_r);
    for (int k = 1; k < WIN_DEPTH; k++) begin
      j = int'(s) - 1 - k;
      if ((k < int'(s)) && a[j[4:0]]) begin
        rec = rec ^ win_r[k-1];
      end
    end
    v_new = (i_r <= {1'b0, s}) ? shifted_m : rec;
  end

  assign dv      = ((d_r == 4'd0) && c_ok) ? (32'h1 << 5'(6'd32 - carry_r)) : 32'h0;
  assign v_final = stat.direct ? dv : win_r[0];
  assign x       = stat.points_zero ? 32'h0 : (prev_r[d_r] ^ v_final);

  assign stat.exhausted   = (points_r == {1'b0, limit_r});
  assign stat.points_zero = (points_r == 33'd0);
  assign stat.direct      = (d_r == 4'd0) || stat.points_zero || !c_ok || (s == 5'd0);
  assign stat.step_last   = (i_r == carry_r);
  assign stat.dim_last    = ({1'b0, d_r} == 5'(dims_eff - 5'd1));
  assign stat.scan_lsb    = scan_r[0];
  assign stat.out_free    = out_free;

  always_ff @(posedge clk) begin
    rdata_r <= dir_mem[rd_addr];
    if (cmd.accept && (in_data.opcode == OP_LOAD_DIR) && ld_dim_ok && ld_pos_ok) begin
      dir_mem[wr_addr] <= in_data.direction_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.opcode == OP_LOAD_POLY) && ld_dim_ok) begin
      deg_r[in_data.dim_select]   <= in_data.poly_degree;
      coeff_r[in_data.dim_select] <= in_data.poly_coeffs;
    end
    if (cmd.step) begin
      win_r[0] <= v_new;
      for (int k = 1; k < WIN_DEPTH; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
    if (cmd.carry_init) begin
      scan_r <= points_r;
      t_r    <= 6'd1;
    end else if (cmd.carry_shift) begin
      scan_r <= scan_r >> 1;
      t_r    <= t_r + 6'd1;
    end
    if (cmd.emit) begin
      out_r.coordinate    <= x;
      out_r.coord_dim     <= d_r;
      out_r.last_of_point <= stat.dim_last;
      out_r.exhausted     <= 1'b0;
    end else if (cmd.exh) begin
      out_r <= '{coordinate: 32'h0, coord_dim: 4'd0, last_of_point: 1'b0, exhausted: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r    <= '0;
      carry_r     <= 6'd1;
      limit_r     <= 32'd1024;
      dims_r      <= 5'd1;
      d_r         <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        prev_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LIMIT) begin
          limit_r <= cfg_data;
        end else begin
          dims_r <= cfg_data[4:0];
        end
        points_r <= '0;
        carry_r  <= 6'd1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          prev_r[k] <= '0;
        end
      end
      if (cmd.point_start) begin
        d_r <= '0;
      end
      if (cmd.dim_init) begin
        i_r <= 6'd1;
      end else if (cmd.step) begin
        i_r <= i_r + 6'd1;
      end
      if (cmd.emit) begin
        if (!stat.points_zero) begin
          prev_r[d_r] <= x;
        end
        d_r <= d_r + 4'd1;
      end
      if (cmd.point_done) begin
        if (!stat.points_zero) begin
          carry_r <= t_r;
        end
        points_r <= points_r + 33'd1;
      end
      if (cmd.emit || cmd.exh) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SOBOL_ASSERT_NOW(a_carry_nonzero, 1'b1, carry_r != 6'd0)
  `SOBOL_ASSERT_NOW(a_points_bounded, 1'b1, points_r <= {1'b0, limit_r})
  `SOBOL_ASSERT_NOW(a_emit_free, cmd.emit || cmd.exh, out_free)
  `SOBOL_ASSERT_NOW(a_step_range, cmd.step, (i_r != 6'd0) && (i_r <= carry_r))
  `SOBOL_ASSERT_NEXT(a_emit_shows, cmd.emit || cmd.exh, out_valid_r)

endmodule
`default_nettype wire

// File: rtl/sobol_sequence_generator_unit.sv
// Sobol generator top level: one word in, per-dimension coordinate words out.
// Flow: a next-point word is accepted, then each dimension is emitted directly when no
// recurrence is needed, otherwise after iterating bit positions up to c, the carry position
// (at most MAX_BITS); a carry scan ends each nonzero point; load words are taken on acceptance.
// The recurrence runs one bit position at a time (read state, step state) through one memory port.
// Reset (rst_n, synchronous, active low) clears the sequence state and config registers, not the tables.
`default_nettype none
module sobol_sequence_generator_unit #(
  parameter int MAX_DIMS = 16,
  parameter int MAX_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sobol_pkg::sobol_in_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sobol_pkg::sobol_out_t     out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import sobol_pkg::*;

  // The controller sequences each point over its dimensions; the datapath holds the
  // tables, the direction-number window, the previous coordinates and the output word.
  sobol_cmd_t  cmd;
  sobol_stat_t stat;

  sobol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.opcode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The output word register lets the next input word be taken while a result waits.
  sobol_dp #(
    .MAX_DIMS (MAX_DIMS),
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
